// ----- hdl/swm_pkg.sv -----
// swm_pkg: shared constants, types and helpers for the 2-D sliding-window minimum core.
// Used by swm_line_bank, swm_min_tree and sliding_window_2d_minimum_core; no dependencies.
`default_nettype none

package swm_pkg;

    localparam int DATA_W     = 32;
    localparam int SIDE_MAX   = 1024;
    localparam int WIN_MAX    = 16;

    localparam int COORD_W    = $clog2(SIDE_MAX);      // row / column counter
    localparam int SIDE_W     = COORD_W + 1;           // frame_side register
    localparam int SLOT_W     = $clog2(WIN_MAX);       // line-store slot, tree depth
    localparam int WIN_W      = SLOT_W + 1;            // window_side register

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIDE_W;

    // tag pipeline positions: column minimum and window minimum leave their trees here
    localparam int COL_STAGE  = 1 + SLOT_W;
    localparam int ROW_STAGE  = 1 + 2 * SLOT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_SIDE  = 1'b0,
        REG_WINDOW_SIDE = 1'b1
    } cfg_reg_t;

    typedef logic [WIN_MAX-1:0][DATA_W-1:0] lane_vec_t;

    // per-item control that rides along with the data pipeline
    typedef struct packed {
        logic valid;
        logic row_ok;
        logic col_ok;
        logic last;
    } tag_t;

    // two's complement compare
    function automatic logic is_less(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/swm_line_bank.sv -----
// swm_line_bank: one line-store slot, SIDE_MAX words, one shared address, registered read.
// Depends on swm_pkg.
`default_nettype none

module swm_line_bank (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic                       rd_en,
    input  wire logic [swm_pkg::COORD_W-1:0] addr,
    input  wire logic [swm_pkg::DATA_W-1:0]  wr_data,
    output logic      [swm_pkg::DATA_W-1:0]  rd_data
);

    logic [swm_pkg::DATA_W-1:0] mem [swm_pkg::SIDE_MAX];
    logic [swm_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/swm_min_tree.sv -----
// swm_min_tree: binary minimum tree over WIN_MAX masked lanes with a register at every level.
// Depends on swm_pkg. Advances on en.
`default_nettype none

module swm_min_tree (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire swm_pkg::lane_vec_t          lane_value,
    input  wire logic [swm_pkg::WIN_MAX-1:0] lane_keep,
    output logic      [swm_pkg::DATA_W-1:0]  min_value
);

    // heap numbering: node 1 is the root, children of node i are 2i and 2i+1
    logic [swm_pkg::DATA_W-1:0] node_val  [1:swm_pkg::WIN_MAX-1];
    logic                       node_keep [1:swm_pkg::WIN_MAX-1];

    for (genvar i = 1; i < swm_pkg::WIN_MAX; i++)
    begin : g_node
        logic [swm_pkg::DATA_W-1:0] a_val;
        logic [swm_pkg::DATA_W-1:0] b_val;
        logic                       a_keep;
        logic                       b_keep;
        logic                       take_b;
        logic [swm_pkg::DATA_W-1:0] val_reg;
        logic                       keep_reg;

        if (2 * i >= swm_pkg::WIN_MAX)
        begin : g_leaf
            assign a_val  = lane_value[2 * i - swm_pkg::WIN_MAX];
            assign b_val  = lane_value[2 * i + 1 - swm_pkg::WIN_MAX];
            assign a_keep = lane_keep[2 * i - swm_pkg::WIN_MAX];
            assign b_keep = lane_keep[2 * i + 1 - swm_pkg::WIN_MAX];
        end
        else
        begin : g_inner
            assign a_val  = node_val[2 * i];
            assign b_val  = node_val[2 * i + 1];
            assign a_keep = node_keep[2 * i];
            assign b_keep = node_keep[2 * i + 1];
        end

        assign take_b = b_keep && (!a_keep || swm_pkg::is_less(b_val, a_val));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg  <= take_b ? b_val : a_val;
                keep_reg <= a_keep | b_keep;
            end
        end

        assign node_val[i]  = val_reg;
        assign node_keep[i] = keep_reg;
    end

    assign min_value = node_val[1];

endmodule

`default_nettype wire

// ----- hdl/sliding_window_2d_minimum_core.sv -----
// sliding_window_2d_minimum_core: top level of the separable 2-D sliding-window minimum filter.
// Depends on swm_pkg, swm_line_bank and swm_min_tree.
`default_nettype none

// Raster-order 2-D minimum filter. Pixels of a frame_side x frame_side frame arrive one per
// transfer in row-major order; for every position where a full window_side x window_side square
// ends inside the frame, one min_value transfer follows, and the result at the frame's final
// pixel carries frame_last. Other pixels produce nothing. frame_side 0 acts as 1, above 1024 as
// 1024; window_side 0 acts as 1, above 16 as 16; a window larger than the frame gives no results.
// Any configuration write restarts the frame at row 0, column 0; write only while the core is
// idle. Throughput is one pixel per clock while the skid buffer is empty: 16 single-port
// line-store banks (one per row slot) are all read at the current column each cycle, a
// registered 4-level tree forms the column minimum, a 16-entry shift line keeps recent column
// minima and a second 4-level tree forms the window minimum. pixel_ready drops only while the
// one-entry skid buffer behind the output register is occupied.
module sliding_window_2d_minimum_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_write,
    input  wire logic [swm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swm_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                           pixel_valid,
    output logic                                pixel_ready,
    input  wire logic signed [swm_pkg::DATA_W-1:0] pixel_value,

    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic signed [swm_pkg::DATA_W-1:0]   min_value,
    output logic                                frame_last
);

    // ---------------------------------------------------------------------------------------
    // Configuration registers and their clamped forms
    // ---------------------------------------------------------------------------------------
    logic [swm_pkg::SIDE_W-1:0]  frame_side_reg;
    logic [swm_pkg::WIN_W-1:0]   window_side_reg;
    logic [swm_pkg::SIDE_W-1:0]  fs_eff;
    logic [swm_pkg::SIDE_W-1:0]  fs_less1;
    logic [swm_pkg::COORD_W-1:0] fs_m1;
    logic [swm_pkg::WIN_W-1:0]   ws_eff;
    logic [swm_pkg::WIN_W-1:0]   ws_less1;
    logic [swm_pkg::SLOT_W-1:0]  ws_m1;

    always_comb
    begin
        if (frame_side_reg == '0)
        begin
            fs_eff = swm_pkg::SIDE_W'(1);
        end
        else if (frame_side_reg > swm_pkg::SIDE_W'(swm_pkg::SIDE_MAX))
        begin
            fs_eff = swm_pkg::SIDE_W'(swm_pkg::SIDE_MAX);
        end
        else
        begin
            fs_eff = frame_side_reg;
        end

        if (window_side_reg == '0)
        begin
            ws_eff = swm_pkg::WIN_W'(1);
        end
        else if (window_side_reg > swm_pkg::WIN_W'(swm_pkg::WIN_MAX))
        begin
            ws_eff = swm_pkg::WIN_W'(swm_pkg::WIN_MAX);
        end
        else
        begin
            ws_eff = window_side_reg;
        end
    end

    assign fs_less1 = fs_eff - swm_pkg::SIDE_W'(1);
    assign fs_m1    = fs_less1[swm_pkg::COORD_W-1:0];
    assign ws_less1 = ws_eff - swm_pkg::WIN_W'(1);
    assign ws_m1    = ws_less1[swm_pkg::SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_side_reg  <= swm_pkg::SIDE_W'(swm_pkg::SIDE_MAX);
            window_side_reg <= swm_pkg::WIN_W'(3);
        end
        else if (cfg_write)
        begin
            unique case (swm_pkg::cfg_reg_t'(cfg_index))
                swm_pkg::REG_FRAME_SIDE:  frame_side_reg  <= cfg_data;
                swm_pkg::REG_WINDOW_SIDE: window_side_reg <= cfg_data[swm_pkg::WIN_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage 0: position counters, line-store write and read
    // ---------------------------------------------------------------------------------------
    logic                        skid_valid_reg;
    logic                        en;        // whole pipeline advances
    logic                        accept;
    logic [swm_pkg::COORD_W-1:0] row_reg;
    logic [swm_pkg::COORD_W-1:0] column_reg;
    logic [swm_pkg::SLOT_W-1:0]  slot;
    logic                        row_end;
    logic                        col_end;
    logic [swm_pkg::WIN_MAX-1:0] col_keep;
    swm_pkg::tag_t               tag_next;

    assign en          = !skid_valid_reg;
    assign pixel_ready = en;
    assign accept      = pixel_valid && en;

    assign slot    = row_reg[swm_pkg::SLOT_W-1:0];
    assign row_end = (row_reg == fs_m1);
    assign col_end = (column_reg == fs_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            column_reg <= '0;
        end
        else if (cfg_write)
        begin
            row_reg    <= '0;
            column_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                column_reg <= '0;
                row_reg    <= row_end ? '0 : row_reg + swm_pkg::COORD_W'(1);
            end
            else
            begin
                column_reg <= column_reg + swm_pkg::COORD_W'(1);
            end
        end
    end

    // keep the slots that hold the current row and the ws-1 rows above it
    always_comb
    begin
        logic [swm_pkg::SLOT_W-1:0] slot_gap;
        for (int b = 0; b < swm_pkg::WIN_MAX; b++)
        begin
            slot_gap    = slot - swm_pkg::SLOT_W'(b);
            col_keep[b] = swm_pkg::WIN_W'(slot_gap) < ws_eff;
        end
    end

    always_comb
    begin
        tag_next.valid  = accept;
        tag_next.row_ok = row_reg >= swm_pkg::COORD_W'(ws_m1);
        tag_next.col_ok = column_reg >= swm_pkg::COORD_W'(ws_m1);
        tag_next.last   = row_end && col_end;
    end

    swm_pkg::lane_vec_t bank_rd;

    for (genvar b = 0; b < swm_pkg::WIN_MAX; b++)
    begin : g_bank
        swm_line_bank u_bank (
            .clk     (clk),
            .wr_en   (accept && (slot == swm_pkg::SLOT_W'(b))),
            .rd_en   (en),
            .addr    (column_reg),
            .wr_data (pixel_value),
            .rd_data (bank_rd[b])
        );
    end

    // ---------------------------------------------------------------------------------------
    // Tag pipeline; stage 1 data registers alongside the bank read data
    // ---------------------------------------------------------------------------------------
    swm_pkg::tag_t               tag_reg [1:swm_pkg::ROW_STAGE];
    logic [swm_pkg::DATA_W-1:0]  s1_value_reg;
    logic [swm_pkg::SLOT_W-1:0]  s1_slot_reg;
    logic [swm_pkg::WIN_MAX-1:0] s1_keep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= swm_pkg::ROW_STAGE; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[1] <= tag_next;
            for (int i = 2; i <= swm_pkg::ROW_STAGE; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_value_reg <= pixel_value;
            s1_slot_reg  <= slot;
            s1_keep_reg  <= col_keep;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Column minimum: own slot takes the fresh pixel, the others the stored rows
    // ---------------------------------------------------------------------------------------
    swm_pkg::lane_vec_t         col_lane;
    logic [swm_pkg::DATA_W-1:0] col_min;

    always_comb
    begin
        for (int b = 0; b < swm_pkg::WIN_MAX; b++)
        begin
            col_lane[b] = (s1_slot_reg == swm_pkg::SLOT_W'(b)) ? s1_value_reg : bank_rd[b];
        end
    end

    swm_min_tree u_col_tree (
        .clk        (clk),
        .en         (en),
        .lane_value (col_lane),
        .lane_keep  (s1_keep_reg),
        .min_value  (col_min)
    );

    // ---------------------------------------------------------------------------------------
    // Shift line of column minima and window minimum
    // ---------------------------------------------------------------------------------------
    swm_pkg::lane_vec_t          win_reg;    // element 0 is the newest column minimum
    swm_pkg::lane_vec_t          row_lane;
    logic [swm_pkg::WIN_MAX-1:0] row_keep;
    logic                        win_shift;
    logic [swm_pkg::DATA_W-1:0]  row_min;

    assign win_shift = en && tag_reg[swm_pkg::COL_STAGE].valid && tag_reg[swm_pkg::COL_STAGE].row_ok;
    assign row_lane  = {win_reg[swm_pkg::WIN_MAX-2:0], col_min};

    always_comb
    begin
        for (int j = 0; j < swm_pkg::WIN_MAX; j++)
        begin
            row_keep[j] = swm_pkg::WIN_W'(j) < ws_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_shift)
        begin
            win_reg <= row_lane;
        end
    end

    swm_min_tree u_row_tree (
        .clk        (clk),
        .en         (en),
        .lane_value (row_lane),
        .lane_keep  (row_keep),
        .min_value  (row_min)
    );

    // ---------------------------------------------------------------------------------------
    // Output register with one-entry skid buffer
    // ---------------------------------------------------------------------------------------
    logic                       produce;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic [swm_pkg::DATA_W-1:0] min_value_reg;
    logic [swm_pkg::DATA_W-1:0] min_value_next;
    logic                       frame_last_reg;
    logic                       frame_last_next;
    logic                       skid_valid_next;
    logic [swm_pkg::DATA_W-1:0] skid_value_reg;
    logic [swm_pkg::DATA_W-1:0] skid_value_next;
    logic                       skid_last_reg;
    logic                       skid_last_next;

    assign produce = en && tag_reg[swm_pkg::ROW_STAGE].valid
                     && tag_reg[swm_pkg::ROW_STAGE].row_ok && tag_reg[swm_pkg::ROW_STAGE].col_ok;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        min_value_next    = min_value_reg;
        frame_last_next   = frame_last_reg;
        skid_valid_next   = skid_valid_reg;
        skid_value_next   = skid_value_reg;
        skid_last_next    = skid_last_reg;

        if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                min_value_next  = skid_value_reg;
                frame_last_next = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            if (!result_valid_reg || result_ready)
            begin
                result_valid_next = 1'b1;
                min_value_next    = row_min;
                frame_last_next   = tag_reg[swm_pkg::ROW_STAGE].last;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_value_next = row_min;
                skid_last_next  = tag_reg[swm_pkg::ROW_STAGE].last;
            end
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_value_reg  <= min_value_next;
        frame_last_reg <= frame_last_next;
        skid_value_reg <= skid_value_next;
        skid_last_reg  <= skid_last_next;
    end

    assign result_valid = result_valid_reg;
    assign min_value    = min_value_reg;
    assign frame_last   = frame_last_reg;

    // ---------------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------------
    a_skid_behind_output : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid buffer holds a result while the output register is empty");

    a_column_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_write) |-> column_reg <= fs_m1)
        else $error("column counter ran past the frame edge");

    a_row_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_write) |-> row_reg <= fs_m1)
        else $error("row counter ran past the frame edge");

    a_stall_freezes_tags : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(tag_reg[swm_pkg::ROW_STAGE]))
        else $error("pipeline moved while the skid buffer was full");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for sliding_window_2d_minimum_core, raster frames in, window minima out.
// Depends on swm_pkg and the core RTL only; a local line-store predictor supplies expected minima.

module tb;

    // Timing and run shape
    localparam int HALF_PERIOD   = 6;      // 12 ns clock
    localparam int QUIET_CYCLES  = 24;     // margin on top of the core latency
    localparam int STUCK_LIMIT   = 3000;   // cycles with work pending and no transfer
    localparam int HOLD_CYCLES   = 200;    // one long receiver hold-off
    localparam int RANDOM_PIXELS = 150;    // random phases; directed phases add about 400

    typedef struct packed {
        logic signed [swm_pkg::DATA_W-1:0] min_value;
        logic                              frame_last;
    } window_result_t;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 cfg_write    = 1'b0;
    logic [swm_pkg::CFG_IDX_W-1:0]        cfg_index    = swm_pkg::REG_FRAME_SIDE;
    logic [swm_pkg::CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                                 pixel_valid  = 1'b0;
    logic                                 pixel_ready;
    logic signed [swm_pkg::DATA_W-1:0]    pixel_value  = '0;
    logic                                 result_valid;
    logic                                 result_ready = 1'b0;
    logic signed [swm_pkg::DATA_W-1:0]    min_value;
    logic                                 frame_last;

    // Stimulus feed and expected minima, oldest first
    logic signed [swm_pkg::DATA_W-1:0]    pixel_feed[$];
    window_result_t                       pending_mins[$];

    // Predictor state: register copies, raster position, line store, column-minimum line
    logic [swm_pkg::SIDE_W-1:0]           frame_reg  = 11'd1024;
    logic [swm_pkg::WIN_W-1:0]            window_reg = 5'd3;
    int unsigned                          row_pos    = 0;
    int unsigned                          col_pos    = 0;
    logic signed [swm_pkg::DATA_W-1:0]    line_mem [swm_pkg::WIN_MAX*swm_pkg::SIDE_MAX];
    logic signed [swm_pkg::DATA_W-1:0]    col_min_line [swm_pkg::WIN_MAX];

    // Pacing controls, changed only while the core is idle
    bit                          send_eager = 1'b0;
    bit                          recv_eager = 1'b0;
    bit                          hold_armed = 1'b0;

    int unsigned                 error_count   = 0;
    int unsigned                 pixels_sent   = 0;
    int unsigned                 results_seen  = 0;
    int unsigned                 settings_used = 0;
    int unsigned                 stuck_cycles  = 0;

    sliding_window_2d_minimum_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .min_value    (min_value),
        .frame_last   (frame_last)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: one accepted pixel in, zero or one window minimum queued.
    // Column minimum over the last win rows at this column, then minimum
    // over the last win column minima of this row.
    // ------------------------------------------------------------------
    task automatic filter_pixel(input logic signed [swm_pkg::DATA_W-1:0] pix);
        int unsigned                       side;
        int unsigned                       win;
        int unsigned                       r;
        int unsigned                       c;
        int unsigned                       k;
        logic signed [swm_pkg::DATA_W-1:0] col_min;
        logic signed [swm_pkg::DATA_W-1:0] win_min;
        window_result_t                    res;

        // out-of-range register values clamp
        side = (frame_reg == 0) ? 1 :
               ((frame_reg > swm_pkg::SIDE_MAX) ? swm_pkg::SIDE_MAX : frame_reg);
        win  = (window_reg == 0) ? 1 :
               ((window_reg > swm_pkg::WIN_MAX) ? swm_pkg::WIN_MAX : window_reg);
        r = (row_pos >= side) ? 0 : row_pos;
        c = (col_pos >= side) ? 0 : col_pos;

        line_mem[(r % swm_pkg::WIN_MAX) * swm_pkg::SIDE_MAX + c] = pix;

        if (r + 1 >= win)
        begin
            col_min = pix;
            for (k = 1; k < win; k++)
                if (line_mem[((r - k) % swm_pkg::WIN_MAX) * swm_pkg::SIDE_MAX + c] < col_min)
                    col_min = line_mem[((r - k) % swm_pkg::WIN_MAX) * swm_pkg::SIDE_MAX + c];
            for (k = swm_pkg::WIN_MAX - 1; k > 0; k--)
                col_min_line[k] = col_min_line[k - 1];
            col_min_line[0] = col_min;

            if (c + 1 >= win)
            begin
                win_min = col_min_line[0];
                for (k = 1; k < win; k++)
                    if (col_min_line[k] < win_min)
                        win_min = col_min_line[k];
                res.min_value  = win_min;
                res.frame_last = (r == side - 1) && (c == side - 1);
                pending_mins.push_back(res);
            end
        end

        // raster advance, wrap at frame end
        c++;
        if (c >= side)
        begin
            c = 0;
            r++;
            if (r >= side)
                r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: valid held with stable data until the transfer; after
    // each transfer a random gap (none while send_eager is set).
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bit offering;
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel_value <= '0;
            send_gap = 0;
        end
        else
        begin
            offering = pixel_valid;
            if (pixel_valid && pixel_ready)
            begin
                filter_pixel(pixel_value);
                pixels_sent++;
                offering = 1'b0;
                send_gap = send_eager ? 0 : $urandom_range(0, 9);
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pixel_feed.size() > 0)
                begin
                    pixel_value <= pixel_feed.pop_front();
                    offering = 1'b1;
                end
            end
            pixel_valid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each transfer against the oldest expected
    // minimum, then drops ready for a random stretch. When armed, the first
    // transfer starts one long hold-off so the core backs up into its input.
    // ------------------------------------------------------------------
    int unsigned recv_stall = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_stall = 0;
            hold_left  = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (pending_mins.size() == 0)
                begin
                    error_count++;
                    $display("ERROR %0t: unexpected result min_value %0d frame_last %0b",
                             $time, min_value, frame_last);
                end
                else
                begin
                    want = pending_mins.pop_front();
                    if (min_value !== want.min_value)
                    begin
                        error_count++;
                        $display("ERROR %0t: min_value expected %0d actual %0d",
                                 $time, want.min_value, min_value);
                    end
                    if (frame_last !== want.frame_last)
                    begin
                        error_count++;
                        $display("ERROR %0t: frame_last expected %0b actual %0b",
                                 $time, want.frame_last, frame_last);
                    end
                end
                recv_stall = recv_eager ? 0 : $urandom_range(0, 9);
                if (hold_armed && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog: sampled mid-cycle, counts cycles with work pending and no transfer
    always @(negedge clk)
    begin
        if (rst_n && (pixel_valid || pending_mins.size() != 0) &&
            !(pixel_valid && pixel_ready) && !(result_valid && result_ready))
            stuck_cycles++;
        else
            stuck_cycles = 0;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Timeout at %0t: no transfer for %0d cycles, %0d minima outstanding",
                     $time, stuck_cycles, pending_mins.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Register write; the predictor copy follows, and any write restarts the frame
    task automatic write_reg(input swm_pkg::cfg_reg_t idx, input int unsigned val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[swm_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == swm_pkg::REG_FRAME_SIDE)
            frame_reg = val[swm_pkg::SIDE_W-1:0];
        else
            window_reg = val[swm_pkg::WIN_W-1:0];
        row_pos = 0;
        col_pos = 0;
        @(negedge clk);
    endtask

    // Wait until the feed is empty, the last pixel is taken and every minimum has
    // arrived, then let extra cycles pass for pixels that produce no result.
    task automatic wait_quiet(input int unsigned extra);
        while (pixel_feed.size() != 0 || pixel_valid || pending_mins.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Mix of extremes, near-ties around zero and full-range values
    function automatic logic signed [swm_pkg::DATA_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};
            1:       return {1'b0, {(swm_pkg::DATA_W-1){1'b1}}};
            2, 3:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom();
        endcase
    endfunction

    // One setting, n random pixels; with split the sender stops halfway until all
    // expected minima are back.
    task automatic run_phase(input int unsigned side, input int unsigned win,
                             input int unsigned n, input bit split);
        int unsigned i;
        if ($urandom_range(0, 1))
        begin
            write_reg(swm_pkg::REG_FRAME_SIDE, side);
            write_reg(swm_pkg::REG_WINDOW_SIDE, win);
        end
        else
        begin
            write_reg(swm_pkg::REG_WINDOW_SIDE, win);
            write_reg(swm_pkg::REG_FRAME_SIDE, side);
        end
        settings_used++;
        for (i = 0; i < n; i++)
        begin
            if (split && i == n / 2)
                wait_quiet(0);
            pixel_feed.push_back(pick_pixel());
        end
        wait_quiet(QUIET_CYCLES);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned random_pixels;
        int unsigned pick;
        int unsigned side;
        int unsigned win;
        int unsigned eff;
        int unsigned n;
        int unsigned i;

        random_pixels = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: 1024-wide frame, 3x3 window; a few pixels of row 0 give nothing
        settings_used++;
        for (i = 0; i < 8; i++)
            pixel_feed.push_back(pick_pixel());
        wait_quiet(QUIET_CYCLES);

        // Window side keeps its reset value of 3 over a 4x4 frame: four minima
        write_reg(swm_pkg::REG_FRAME_SIDE, 4);
        settings_used++;
        for (i = 0; i < 16; i++)
            pixel_feed.push_back(pick_pixel());
        wait_quiet(QUIET_CYCLES);

        // Directed: 3x3 frame, 2x2 window, with extreme values in every window
        write_reg(swm_pkg::REG_FRAME_SIDE, 3);
        write_reg(swm_pkg::REG_WINDOW_SIDE, 2);
        settings_used++;
        pixel_feed.push_back(32'sh7FFF_FFFF);
        pixel_feed.push_back(32'sh8000_0000);
        pixel_feed.push_back(32'sh0000_0000);
        pixel_feed.push_back(-32'sd1);
        pixel_feed.push_back(32'sd1);
        pixel_feed.push_back(32'sh7FFF_FFFF);
        pixel_feed.push_back(32'sh8000_0000);
        pixel_feed.push_back(32'sd5);
        pixel_feed.push_back(-32'sd5);
        // frame wraps: the next row 0 yields nothing, then a write cuts it short
        pixel_feed.push_back(32'sd0);
        pixel_feed.push_back(32'sh7FFF_FFFF);
        pixel_feed.push_back(32'sd3);
        wait_quiet(QUIET_CYCLES);

        // Zero registers act as 1: every pixel is its own frame and its own result
        write_reg(swm_pkg::REG_WINDOW_SIDE, 0);
        write_reg(swm_pkg::REG_FRAME_SIDE, 0);
        settings_used++;
        pixel_feed.push_back(32'sh8000_0000);
        pixel_feed.push_back(32'sh7FFF_FFFF);
        pixel_feed.push_back(-32'sd1);
        wait_quiet(QUIET_CYCLES);

        // Window wider than the frame (and above the maximum): no result ever
        write_reg(swm_pkg::REG_FRAME_SIDE, 2);
        write_reg(swm_pkg::REG_WINDOW_SIDE, 31);
        settings_used++;
        for (i = 0; i < 4; i++)
            pixel_feed.push_back(pick_pixel());
        wait_quiet(QUIET_CYCLES);

        // Frame side above the maximum clamps to 1024; window 1 passes pixels through
        write_reg(swm_pkg::REG_FRAME_SIDE, 2047);
        write_reg(swm_pkg::REG_WINDOW_SIDE, 1);
        settings_used++;
        for (i = 0; i < 5; i++)
            pixel_feed.push_back(pick_pixel());
        wait_quiet(QUIET_CYCLES);

        // Back-pressure: eager sender, receiver holds off on the first result so the
        // core fills and stalls its input; the sender also stops halfway to drain.
        send_eager = 1'b1;
        recv_eager = 1'b0;
        hold_armed = 1'b1;
        run_phase(8, 1, 64, 1'b1);
        send_eager = 1'b0;

        // Largest window (31 clamps to 16) over a 17x17 frame: all 16 row slots in use
        run_phase(17, 31, 17 * 17, 1'b0);

        // Random settings: mostly small full frames, some cut short by the next
        // write, some wide partial frames, some 1x1 frames and oversize windows.
        while (random_pixels < RANDOM_PIXELS)
        begin
            send_eager = ($urandom_range(0, 3) == 0);
            recv_eager = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                side = $urandom_range(0, 1);
                win  = $urandom_range(0, 2);
            end
            else if (pick == 1)
            begin
                side = $urandom_range(2, 6);
                win  = $urandom_range(side + 1, 31);
            end
            else if (pick == 2)
            begin
                side = $urandom_range(20, 48);
                win  = $urandom_range(1, 4);
            end
            else
            begin
                side = $urandom_range(2, 10);
                win  = $urandom_range(1, side);
            end
            eff = (side == 0) ? 1 : side;

            if (pick == 2)
                n = $urandom_range(eff * win, eff * (win + 3));
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, eff * eff);
            else
                n = eff * eff * $urandom_range(1, 2);
            // the last phase takes only what is left of the budget
            if (n > RANDOM_PIXELS - random_pixels)
                n = RANDOM_PIXELS - random_pixels;

            run_phase(side, win, n, ($urandom_range(0, 7) == 0));
            random_pixels += n;
        end

        wait_quiet(QUIET_CYCLES);
        $display("Covered %0d pixel transfers and %0d window minima over %0d register settings,",
                 pixels_sent, results_seen, settings_used);
        $display("with clamped registers, oversize windows, frame wrap and restarts under stalls.");
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/swm_pkg.sv
hdl/swm_line_bank.sv
hdl/swm_min_tree.sv
hdl/sliding_window_2d_minimum_core.sv
bench/tb.sv
